// ----- hw/rtl/smd_pkg.sv -----
// types and constants of the sustained motion detector
package smd_pkg;

    localparam int AXIS_W  = 16;
    localparam int MAG_W   = 16;
    localparam int SUM_W   = 32;
    localparam int REM_W   = 17;
    localparam int THR_W   = 16;
    localparam int HOLD_W  = 10;
    localparam int COOL_W  = 16;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;
    localparam int STEP_W  = 4;

    localparam logic [CFG_A_W-1:0] CFG_RANGE_THRESHOLD = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_HOLD_LENGTH     = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_COOLDOWN_TICKS  = 2'd2;

    localparam logic [THR_W-1:0]  RST_RANGE_THRESHOLD = 16'd250;
    localparam logic [HOLD_W-1:0] RST_HOLD_LENGTH     = 10'd25;
    localparam logic [COOL_W-1:0] RST_COOLDOWN_TICKS  = 16'd600;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic                     sample_ok;
    } t_in_item;

    typedef struct packed {
        logic             event_fired;
        logic [MAG_W-1:0] window_range;
        logic             window_full;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_WRITE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/sustained_motion_detector_top.sv -----
// sustained motion detector: serial magnitude, ring scan and event logic
//
// input channel (i_in_valid / o_in_ready / i_in_item) takes one sample tick
// per item; output channel (o_out_valid / i_out_ready / o_out_item) returns
// exactly one result item per tick, in order
// configuration: i_cfg_we with i_cfg_addr and i_cfg_wdata writes one register
// (0 range threshold, 1 hold length, 2 cooldown ticks); other indexes ignored
// a valid sample runs through a shift-add squarer (msb first),
// a restoring square root (one 2-bit digit per step), one ring write
// and, once the window is full, a scan of the ring memory (one read port)
// one item is worked on at a time: o_in_ready is high only when idle
// the result sits in an output register; a stalled receiver holds the block
// in its final step until that register frees, and no item is lost
// reset clears counters, run, cooldown and the output valid, and restores
// the register defaults; the ring is left as is and is only read once full
module sustained_motion_detector_top
    import smd_pkg::*;
#(
    parameter int WINDOW = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_A_W-1:0]   i_cfg_addr,
    input  logic [CFG_D_W-1:0]   i_cfg_wdata
);

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);

    // control state
    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic [CW-1:0]       r_scan;
    logic [AW-1:0]       r_wp;
    logic [CW-1:0]       r_fill;
    logic [HOLD_W-1:0]   r_run;
    logic [COOL_W-1:0]   r_cool;
    logic                r_ok;
    logic                r_eval;
    logic                r_out_valid;

    // configuration
    logic [THR_W-1:0]    r_thr;
    logic [HOLD_W-1:0]   r_hold;
    logic [COOL_W-1:0]   r_cool_len;

    // datapath
    logic [MAG_W-1:0]    r_ax, r_ay, r_az;
    logic [MAG_W-1:0]    r_bx, r_by, r_bz;
    logic [SUM_W-1:0]    r_acc;
    logic [REM_W-1:0]    r_rem;
    logic [MAG_W-1:0]    r_root;
    logic [MAG_W-1:0]    r_lo, r_hi;
    logic [MAG_W-1:0]    r_rd_data;
    t_out_item           r_out_item;

    // ring memory
    logic [MAG_W-1:0]    r_ring [WINDOW];

    // combinational helpers
    logic                accept;
    logic                out_free;
    logic                step_last;
    logic                scan_last;
    logic                load_out;
    logic [SUM_W-1:0]    acc_next;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                root_bit;
    logic [AW-1:0]       rd_addr;
    logic [MAG_W-1:0]    range;
    logic                moving;
    logic [HOLD_W-1:0]   need;
    logic [HOLD_W-1:0]   run_inc;
    logic                hold_hit;
    logic                fire;

    function automatic logic [MAG_W-1:0] abs_axis(input logic signed [AXIS_W-1:0] v);
        logic [MAG_W-1:0] u;
        u = MAG_W'(v);
        return v[AXIS_W-1] ? (~u + 1'b1) : u;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_item.sample_ok ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                if (step_last) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (step_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = (r_fill < CW'(WINDOW)) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        load_out   = (r_state == S_DONE) && out_free;
    end

    assign accept    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign step_last = (r_step == {STEP_W{1'b1}});
    assign scan_last = (r_scan == CW'(WINDOW));

    // msb-first shift-add of the three squares at once
    assign acc_next = {r_acc[SUM_W-2:0], 1'b0}
                    + {{(SUM_W-MAG_W){1'b0}}, (r_bx[MAG_W-1] ? r_ax : '0)}
                    + {{(SUM_W-MAG_W){1'b0}}, (r_by[MAG_W-1] ? r_ay : '0)}
                    + {{(SUM_W-MAG_W){1'b0}}, (r_bz[MAG_W-1] ? r_az : '0)};

    // one root digit per cycle
    assign rem_sh   = {r_rem, r_acc[SUM_W-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign root_bit = (rem_sh >= trial);

    assign rd_addr = (r_scan < CW'(WINDOW)) ? r_scan[AW-1:0] : '0;

    // evaluation of the scanned window
    assign range    = r_hi - r_lo;
    assign moving   = (range >= r_thr);
    assign need     = (r_hold == '0) ? HOLD_W'(1) : r_hold;
    assign run_inc  = r_run + 1'b1;
    assign hold_hit = r_eval && moving && (run_inc >= need);
    assign fire     = hold_hit && (r_cool == '0);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_scan      <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_run       <= '0;
            r_cool      <= '0;
            r_ok        <= 1'b0;
            r_eval      <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= RST_RANGE_THRESHOLD;
            r_hold      <= RST_HOLD_LENGTH;
            r_cool_len  <= RST_COOLDOWN_TICKS;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_RANGE_THRESHOLD: r_thr      <= i_cfg_wdata[THR_W-1:0];
                    CFG_HOLD_LENGTH:     r_hold     <= i_cfg_wdata[HOLD_W-1:0];
                    CFG_COOLDOWN_TICKS:  r_cool_len <= i_cfg_wdata[COOL_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_step <= '0;
                r_ok   <= i_in_item.sample_ok;
                r_eval <= 1'b0;
            end
            if ((r_state == S_MUL) || (r_state == S_SQRT)) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == S_WRITE) begin
                r_scan <= '0;
                r_wp   <= (r_wp == AW'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill < CW'(WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_eval <= 1'b1;
                end
            end
            if (r_state == S_SCAN) begin
                r_scan <= r_scan + 1'b1;
            end
            if (load_out) begin
                if (r_eval) begin
                    if (!moving || hold_hit) begin
                        r_run <= '0;
                    end else begin
                        r_run <= run_inc;
                    end
                end
                if (fire) begin
                    r_cool <= r_cool_len;
                end else if (r_cool != '0) begin
                    r_cool <= r_cool - 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax   <= abs_axis(i_in_item.accel_x);
            r_ay   <= abs_axis(i_in_item.accel_y);
            r_az   <= abs_axis(i_in_item.accel_z);
            r_bx   <= abs_axis(i_in_item.accel_x);
            r_by   <= abs_axis(i_in_item.accel_y);
            r_bz   <= abs_axis(i_in_item.accel_z);
            r_acc  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (r_state == S_MUL) begin
            r_acc <= acc_next;
            r_bx  <= {r_bx[MAG_W-2:0], 1'b0};
            r_by  <= {r_by[MAG_W-2:0], 1'b0};
            r_bz  <= {r_bz[MAG_W-2:0], 1'b0};
        end
        if (r_state == S_SQRT) begin
            r_acc  <= {r_acc[SUM_W-3:0], 2'b00};
            r_root <= {r_root[MAG_W-2:0], root_bit};
            r_rem  <= root_bit ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        end
        if ((r_state == S_SCAN) && (r_scan != '0)) begin
            if (r_scan == CW'(1)) begin
                r_lo <= r_rd_data;
                r_hi <= r_rd_data;
            end else begin
                if (r_rd_data < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if (r_rd_data > r_hi) begin
                    r_hi <= r_rd_data;
                end
            end
        end
        if (load_out) begin
            r_out_item.event_fired  <= fire;
            r_out_item.window_range <= r_eval ? range : '0;
            r_out_item.window_full  <= r_eval;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_ring[r_wp] <= r_root;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an accepted item always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item left the block idle");

    // fill count saturates at the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW))
        else $error("fill count beyond window depth");

    // an evaluated result only comes from a full window
    a_full_means_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.window_full) |-> (r_fill == CW'(WINDOW)))
        else $error("window evaluated before it was full");

    // an event only fires on an evaluated tick of a valid sample
    a_fire_needs_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && fire) |-> (r_eval && r_ok))
        else $error("event fired without an evaluation");

    // a fired event loads the cooldown
    a_fire_loads_cool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && fire) |=> (r_cool == $past(r_cool_len)))
        else $error("cooldown not loaded after an event");

endmodule

// ----- sim/sustained_motion_detector_checker.sv -----
// checker for the sustained motion detector: mirrors registers, predicts each tick, compares
module sustained_motion_detector_checker
    import smd_pkg::*;
#(
    parameter int WINDOW = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_item           i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_item          i_out_item,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_D_W-1:0] i_cfg_wdata,
    output int                 o_mismatches,
    output int                 o_pending
);

    // register copies
    logic [THR_W-1:0]  thr;
    logic [HOLD_W-1:0] hold;
    logic [COOL_W-1:0] cool_len;

    // detector state
    logic [MAG_W-1:0]  ring [WINDOW];
    int                wr_pos;
    int                fill_cnt;
    int                run;
    int                cool_left;

    t_out_item         awaited_outcomes [$];

    // floor of the square root, one result bit at a time from the top
    function automatic logic [MAG_W-1:0] floor_root(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root[MAG_W-1:0];
    endfunction

    // outcome of one tick, advancing the detector state
    function automatic t_out_item tick_outcome(input t_in_item s);
        t_out_item        r;
        longint           ax;
        longint           ay;
        longint           az;
        logic [MAG_W-1:0] lo;
        logic [MAG_W-1:0] hi;
        int               need;
        r = '0;
        if (s.sample_ok) begin
            ax = $signed(s.accel_x);
            ay = $signed(s.accel_y);
            az = $signed(s.accel_z);
            ring[wr_pos] = floor_root(ax * ax + ay * ay + az * az);
            wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
            if (fill_cnt < WINDOW) begin
                fill_cnt++;
            end else begin
                lo = ring[0];
                hi = ring[0];
                for (int i = 1; i < WINDOW; i++) begin
                    if (ring[i] < lo) lo = ring[i];
                    if (ring[i] > hi) hi = ring[i];
                end
                r.window_full  = 1'b1;
                r.window_range = hi - lo;
                // a zero hold length acts as one
                need = (hold == 0) ? 1 : int'(hold);
                if (r.window_range < thr) begin
                    run = 0;
                end else begin
                    run++;
                    if (run >= need) begin
                        run = 0;
                        r.event_fired = (cool_left == 0);
                    end
                end
            end
        end
        // cooldown counts every tick, valid or not
        if (r.event_fired) begin
            cool_left = cool_len;
        end else if (cool_left != 0) begin
            cool_left--;
        end
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            o_mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            thr       = RST_RANGE_THRESHOLD;
            hold      = RST_HOLD_LENGTH;
            cool_len  = RST_COOLDOWN_TICKS;
            wr_pos    = 0;
            fill_cnt  = 0;
            run       = 0;
            cool_left = 0;
            awaited_outcomes.delete();
            o_mismatches = 0;
            o_pending    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_RANGE_THRESHOLD: thr      = i_cfg_wdata[THR_W-1:0];
                    CFG_HOLD_LENGTH:     hold     = i_cfg_wdata[HOLD_W-1:0];
                    CFG_COOLDOWN_TICKS:  cool_len = i_cfg_wdata[COOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                awaited_outcomes.push_back(tick_outcome(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result with nothing awaited, expected none, actual %p",
                             $time, i_out_item);
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("event_fired", want.event_fired, i_out_item.event_fired);
                    check_field("window_range", want.window_range, i_out_item.window_range);
                    check_field("window_full", want.window_full, i_out_item.window_full);
                end
            end
            o_pending = awaited_outcomes.size();
        end
    end

endmodule

// ----- sim/tb_sustained_motion_detector_top.sv -----
// testbench top for the sustained motion detector: stimulus, receiver, watchdog and verdict
module tb_sustained_motion_detector_top
    import smd_pkg::*;
();

    localparam int WINDOW      = 40;
    // longest quiet stretch: receiver hold-off plus a slow item and a sender gap, several times
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF    = 300;
    localparam int DRAIN_WAIT  = 100;

    // register index the block must ignore
    localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

    // kinds of random segments
    typedef enum logic [1:0] {
        M_STILL,
        M_SHAKE,
        M_WILD,
        M_GAPS
    } t_motion;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_in_item           in_item;
    logic               out_valid;
    logic               out_ready;
    t_out_item          out_item;
    logic               cfg_we;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [CFG_D_W-1:0] cfg_wdata;

    int                 mismatches;
    int                 pending;

    // random idling on both sides, and the count of receiver hold-off requests
    bit                 idle_on    = 1'b1;
    int                 stall_reqs = 0;

    // current segment: a resting vector and how far samples wander from it
    int                 base_x;
    int                 base_y;
    int                 base_z;
    int                 spread;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sustained_motion_detector_top #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    sustained_motion_detector_checker #(
        .WINDOW(WINDOW)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic t_in_item sample_of(input int x, input int y, input int z, input bit ok);
        t_in_item s;
        s.accel_x   = 16'(x);
        s.accel_y   = 16'(y);
        s.accel_z   = 16'(z);
        s.sample_ok = ok;
        return s;
    endfunction

    // offset within the segment spread
    function automatic int jitter();
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // any 16-bit axis value, with the corners now and then
    function automatic logic [AXIS_W-1:0] wild_axis();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_in_item make_sample(input t_motion m);
        t_in_item s;
        case (m)
            M_STILL, M_SHAKE: begin
                // magnitude hovers around the resting vector, so the window range follows spread
                s.accel_x   = 16'(base_x + jitter());
                s.accel_y   = 16'(base_y + jitter());
                s.accel_z   = 16'(base_z + jitter());
                s.sample_ok = ($urandom_range(0, 19) != 0);
            end
            M_WILD: begin
                s.accel_x   = wild_axis();
                s.accel_y   = wild_axis();
                s.accel_z   = wild_axis();
                s.sample_ok = ($urandom_range(0, 19) != 0);
            end
            default: begin
                // mostly failed reads carrying garbage axes
                s.accel_x   = 16'($urandom_range(0, 65535));
                s.accel_y   = 16'($urandom_range(0, 65535));
                s.accel_z   = 16'($urandom_range(0, 65535));
                s.sample_ok = ($urandom_range(0, 4) == 0);
            end
        endcase
        return s;
    endfunction

    // present one item from a falling edge and return at the falling edge after it is taken;
    // valid stays high on return so back-to-back items keep it up
    task automatic offer(input t_in_item s);
        if (idle_on && $urandom_range(0, 99) < 9) begin
            in_valid = 1'b0;
            // long enough gaps to land on any step of the block's work
            repeat ($urandom_range(1, 90)) @(negedge clk);
        end
        in_item  = s;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait until every awaited result is back and the block is idle
    task automatic settle();
        in_valid = 1'b0;
        while (!(pending == 0 && in_ready)) @(negedge clk);
    endtask

    // one register write per falling edge; the caller drops the enable afterwards
    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
    endtask

    // random segments: still, shaking, wild or gaps, with a little noise of failed reads
    task automatic random_run(input int count);
        int      left;
        int      len;
        t_motion m;
        left = count;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0:       m = M_GAPS;
                1, 2, 3: m = M_STILL;
                4, 5, 6: m = M_SHAKE;
                default: m = M_WILD;
            endcase
            base_x = int'($urandom_range(0, 40000)) - 20000;
            base_y = int'($urandom_range(0, 40000)) - 20000;
            base_z = int'($urandom_range(0, 40000)) - 20000;
            spread = (m == M_STILL) ? int'($urandom_range(0, 15))
                                    : int'($urandom_range(50, 2500));
            len = $urandom_range(4, 50);
            if (len > left) len = left;
            repeat (len) offer(make_sample(m));
            left -= len;
        end
    endtask

    // registers change only with the block drained; the unused index is poked every time
    task automatic run_phase(input logic [CFG_D_W-1:0] thr, input logic [CFG_D_W-1:0] hold,
                             input logic [CFG_D_W-1:0] cool, input int count);
        write_reg(CFG_RANGE_THRESHOLD, thr);
        write_reg(CFG_HOLD_LENGTH, hold);
        write_reg(CFG_COOLDOWN_TICKS, cool);
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_we = 1'b0;
        random_run(count);
        settle();
    endtask

    // receiver: random stalls, or a long hold-off on each new request
    initial begin : receiver
        int stall_left;
        int stall_seen;
        stall_left = 0;
        stall_seen = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_reqs != stall_seen) begin
                stall_left = HOLD_OFF;
                stall_seen = stall_reqs;
            end
            if (stall_left > 0) begin
                out_ready = 1'b0;
                stall_left--;
            end else begin
                out_ready = !(idle_on && $urandom_range(0, 99) < 9);
            end
        end
    end

    // watchdog: too long without any item moving on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_RANGE_THRESHOLD;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners at reset defaults: largest magnitudes, zero, mixed signs, failed reads
        offer(sample_of(32767, 32767, 32767, 1'b1));
        offer(sample_of(-32768, -32768, -32768, 1'b1));
        offer(sample_of(0, 0, 0, 1'b1));
        offer(sample_of(32767, -32768, 0, 1'b1));
        offer(sample_of(-1, -1, -1, 1'b1));
        offer(sample_of(1, 0, -1, 1'b1));
        offer(sample_of(-32768, 32767, -1, 1'b0));
        offer(sample_of(0, 0, -32768, 1'b1));
        offer(sample_of(-32768, 0, 0, 1'b0));
        offer(sample_of(1000, -1000, 250, 1'b1));
        // fills the window and evaluates under the defaults
        random_run(120);
        settle();

        // zero threshold, hold and cooldown: evaluations fire after old cooldown; no idling here
        idle_on = 1'b0;
        run_phase(16'd0, 16'd0, 16'd0, 100);
        idle_on = 1'b1;

        // top of every register: motion can never reach the threshold
        run_phase(16'hffff, 16'd1023, 16'hffff, 60);

        // hold length written with junk above its 10 bits; the receiver holds off meanwhile
        stall_reqs++;
        run_phase(16'd300, 16'hfc04, 16'd30, 150);

        // fire once, then the long cooldown blocks every later event
        run_phase(16'd40, 16'd1, 16'hffff, 60);

        // short cooldown against a moderate hold
        run_phase(16'd1000, 16'd8, 16'd3, 150);

        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/smd_pkg.sv
hw/rtl/sustained_motion_detector_top.sv
sim/sustained_motion_detector_checker.sv
sim/tb_sustained_motion_detector_top.sv
